### hdl/tws_pkg.sv
package tws_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned SLOTS_DEF         = 64;
  localparam int unsigned SLOT_CAPACITY_DEF = 16;
  localparam int unsigned HANDLE_BITS_DEF   = 16;

  // Fixed field widths
  localparam int unsigned WHEEL_SIZE_W = 7;
  localparam int unsigned DELAY_W      = 8;
  localparam int unsigned HANDLE_W     = 16;
  localparam int unsigned STATUS_W     = 3;

  localparam logic [WHEEL_SIZE_W-1:0] WHEEL_SIZE_RESET = 7'd64;

  // Request kinds on tuser
  localparam logic CMD_SCHEDULE = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ACCEPTED  = 3'd0,
    STAT_TOO_LATE  = 3'd1,
    STAT_SLOT_FULL = 3'd2,
    STAT_DISPATCH  = 3'd3,
    STAT_EMPTY     = 3'd4
  } status_e;

endpackage

### hdl/tws_ram.sv
module tws_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while re_i is low
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/timing_wheel_scheduler_top.sv
// Schedule: reads the fill count of the target slot, then writes it back; a bit-serial
//   reduction of position+delay comes first only beyond a shrunk wheel. A tick reads the
//   fill count of the new slot: an empty slot gives one result, else one entry read per
//   handle. A new request is taken only once the previous one has loaded its last result.
// Reset (async, active low): position 0, wheel size 64, then a clearing pass over the fill
//   memory during which no request is accepted; config writes are always taken.
module timing_wheel_scheduler_top #(
  parameter int unsigned SLOTS         = tws_pkg::SLOTS_DEF,
  parameter int unsigned SLOT_CAPACITY = tws_pkg::SLOT_CAPACITY_DEF,
  parameter int unsigned HANDLE_BITS   = tws_pkg::HANDLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration: wheel_size
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,

  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] delay_ticks, [23:8] handle_id
  input  logic [0:0]  s_axis_tuser,   // [0] command

  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] status, [18:3] due_handle, [23:19] zero
  output logic        m_axis_tlast    // last result of the request
);

  localparam int unsigned WSW   = tws_pkg::WHEEL_SIZE_W;
  localparam int unsigned DLW   = tws_pkg::DELAY_W;
  localparam int unsigned HW    = tws_pkg::HANDLE_W;
  localparam int unsigned STW   = tws_pkg::STATUS_W;
  localparam int unsigned PW    = $clog2(SLOTS);                  // slot index
  localparam int unsigned SZW   = $clog2(SLOTS + 1);              // active size
  localparam int unsigned FW    = $clog2(SLOT_CAPACITY + 1);      // fill count
  localparam int unsigned CW    = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
  localparam int unsigned SUMW  = ((PW > DLW) ? PW : DLW) + 1;    // position + delay
  localparam int unsigned MW    = (SUMW > SZW + 1) ? SUMW : SZW + 1;
  localparam int unsigned RW    = SZW + 1;                        // remainder
  localparam int unsigned CMPW  = (SZW > WSW) ? SZW : WSW;
  localparam int unsigned KW    = $clog2(SUMW);
  localparam int unsigned EDEPTH = SLOTS << CW;
  localparam int unsigned PADW  = 24 - HW - STW;

  // Controller states
  localparam logic [2:0] ST_CLEAR = 3'd0;  // clearing pass over fill memory
  localparam logic [2:0] ST_IDLE  = 3'd1;  // waiting for a request
  localparam logic [2:0] ST_MOD   = 3'd2;  // bit-serial slot reduction
  localparam logic [2:0] ST_REJ   = 3'd3;  // delay out of range
  localparam logic [2:0] ST_SCH   = 3'd4;  // fill read back, append handle or report full
  localparam logic [2:0] ST_TICK  = 3'd5;  // fill of new slot read back
  localparam logic [2:0] ST_DISP  = 3'd6;  // one handle per cycle out while the output is free

  logic [2:0]           state_q, state_d;
  logic [WSW-1:0]       wheel_size_q;
  logic [PW-1:0]        pos_q, pos_d;
  logic [PW-1:0]        clr_q, clr_d;
  logic [PW-1:0]        slot_q, slot_d;
  logic [SUMW-1:0]      sum_q, sum_d;
  logic [RW-1:0]        rem_q, rem_d;
  logic [KW-1:0]        cnt_q, cnt_d;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;
  logic [FW-1:0]        n_q, n_d;
  logic [FW-1:0]        idx_q, idx_d;

  // Output register
  logic                 m_valid_q;
  tws_pkg::status_e     m_status_q;
  logic [HW-1:0]        m_handle_q;
  logic                 m_last_q;
  logic                 out_load;
  tws_pkg::status_e     out_status;
  logic [HW-1:0]        out_handle;
  logic                 out_last;
  logic                 out_free;

  // Memory ports
  logic                 fill_we, fill_re;
  logic [PW-1:0]        fill_waddr, fill_raddr;
  logic [FW-1:0]        fill_wdata, fill_rd;
  logic                 ent_we, ent_re;
  logic [PW+CW-1:0]     ent_waddr, ent_raddr;
  logic [HANDLE_BITS-1:0] ent_wdata, ent_rd;

  // Datapath
  logic [CMPW-1:0]      ws_ext, sz_c;
  logic [SZW-1:0]       size_act;
  logic [MW-1:0]        size_m, sum_m;
  logic [DLW-1:0]       in_delay;
  logic [HW-1:0]        in_handle;
  logic                 in_cmd;
  logic                 delay_big;
  logic [SUMW-1:0]      sum_in;
  logic                 fast_ok;
  logic [PW-1:0]        fast_slot;
  logic                 wrap;
  logic [PW-1:0]        pos_next;
  logic [RW-1:0]        rem_sh, rem_new;
  logic                 full;
  logic [FW-1:0]        idx_next;
  logic                 disp_last;

  assign in_delay  = s_axis_tdata[7:0];
  assign in_handle = s_axis_tdata[23:8];
  assign in_cmd    = s_axis_tuser[0];

  assign cfg_ready_o = 1'b1;

  // Register value saturated into 1..SLOTS
  always_comb begin
    ws_ext = CMPW'(wheel_size_q);
    if (ws_ext == '0) begin
      sz_c = CMPW'(1);
    end else if (ws_ext > CMPW'(SLOTS)) begin
      sz_c = CMPW'(SLOTS);
    end else begin
      sz_c = ws_ext;
    end
    size_act = SZW'(sz_c);
  end

  assign size_m    = MW'(size_act);
  assign delay_big = MW'(in_delay) >= size_m;
  assign sum_in    = SUMW'(pos_q) + SUMW'(in_delay);
  assign sum_m     = MW'(sum_in);
  // Usual case: position inside the wheel, so one subtraction is enough
  assign fast_ok   = sum_m < (size_m << 1);
  assign fast_slot = (sum_m < size_m) ? PW'(sum_m) : PW'(sum_m - size_m);

  assign wrap     = MW'(pos_q) >= (size_m - MW'(1));
  assign pos_next = wrap ? '0 : pos_q + PW'(1);

  // Restoring remainder step, MSB of the sum first
  assign rem_sh  = {rem_q[RW-2:0], sum_q[SUMW-1]};
  assign rem_new = (rem_sh >= RW'(size_act)) ? rem_sh - RW'(size_act) : rem_sh;

  assign full      = fill_rd >= FW'(SLOT_CAPACITY);
  assign idx_next  = idx_q + FW'(1);
  assign disp_last = idx_next == n_q;

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    clr_d    = clr_q;
    slot_d   = slot_q;
    sum_d    = sum_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    handle_d = handle_q;
    n_d      = n_q;
    idx_d    = idx_q;

    out_load   = 1'b0;
    out_status = tws_pkg::STAT_ACCEPTED;
    out_handle = '0;
    out_last   = 1'b1;

    fill_we    = 1'b0;
    fill_waddr = slot_q;
    fill_wdata = '0;
    fill_re    = 1'b0;
    fill_raddr = slot_q;
    ent_we     = 1'b0;
    ent_waddr  = {slot_q, CW'(fill_rd)};
    ent_wdata  = handle_q;
    ent_re     = 1'b0;
    ent_raddr  = {pos_q, CW'(idx_q)};

    s_axis_tready = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_q;
        clr_d      = clr_q + PW'(1);
        if (clr_q == PW'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          handle_d = HANDLE_BITS'(in_handle);
          if (in_cmd == tws_pkg::CMD_TICK) begin
            pos_d      = pos_next;
            fill_re    = 1'b1;
            fill_raddr = pos_next;
            state_d    = ST_TICK;
          end else if (delay_big) begin
            state_d = ST_REJ;
          end else if (fast_ok) begin
            slot_d     = fast_slot;
            fill_re    = 1'b1;
            fill_raddr = fast_slot;
            state_d    = ST_SCH;
          end else begin
            sum_d   = sum_in;
            rem_d   = '0;
            cnt_d   = KW'(SUMW - 1);
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        rem_d = rem_new;
        sum_d = sum_q << 1;
        cnt_d = cnt_q - KW'(1);
        if (cnt_q == '0) begin
          slot_d     = PW'(rem_new);
          fill_re    = 1'b1;
          fill_raddr = PW'(rem_new);
          state_d    = ST_SCH;
        end
      end
      ST_REJ: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_status = tws_pkg::STAT_TOO_LATE;
          state_d    = ST_IDLE;
        end
      end
      ST_SCH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (full) begin
            out_status = tws_pkg::STAT_SLOT_FULL;
          end else begin
            out_status = tws_pkg::STAT_ACCEPTED;
            fill_we    = 1'b1;
            fill_wdata = fill_rd + FW'(1);
            ent_we     = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (fill_rd == '0) begin
          if (out_free) begin
            out_load   = 1'b1;
            out_status = tws_pkg::STAT_EMPTY;
            state_d    = ST_IDLE;
          end
        end else begin
          n_d        = fill_rd;
          idx_d      = '0;
          ent_re     = 1'b1;
          ent_raddr  = {pos_q, CW'(0)};
          // slot empties as it is drained
          fill_we    = 1'b1;
          fill_waddr = pos_q;
          fill_wdata = '0;
          state_d    = ST_DISP;
        end
      end
      ST_DISP: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_status = tws_pkg::STAT_DISPATCH;
          out_handle = HW'(ent_rd);
          out_last   = disp_last;
          if (disp_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d     = idx_next;
            ent_re    = 1'b1;
            ent_raddr = {pos_q, CW'(idx_next)};
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      pos_q        <= '0;
      clr_q        <= '0;
      wheel_size_q <= tws_pkg::WHEEL_SIZE_RESET;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      clr_q   <= clr_d;
      if (cfg_valid_i) begin
        wheel_size_q <= cfg_data_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    sum_q    <= sum_d;
    rem_q    <= rem_d;
    cnt_q    <= cnt_d;
    handle_q <= handle_d;
    n_q      <= n_d;
    idx_q    <= idx_d;
    if (out_load) begin
      m_status_q <= out_status;
      m_handle_q <= out_handle;
      m_last_q   <= out_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PADW{1'b0}}, m_handle_q, m_status_q};
  assign m_axis_tlast  = m_last_q;

  // Per-slot fill counts
  tws_ram #(
    .WIDTH (FW),
    .DEPTH (SLOTS)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .re_i    (fill_re),
    .raddr_i (fill_raddr),
    .rdata_o (fill_rd)
  );

  // Stored handles, addressed {slot, entry}
  tws_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (EDEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rd)
  );

`ifndef SYNTHESIS
  // A fill count written back never exceeds the slot capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_we && state_q == ST_SCH) |-> fill_wdata <= FW'(SLOT_CAPACITY))
    else $error("fill count above capacity");

  // Dispatch index stays below the count latched from the slot
  a_disp_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DISP |-> (idx_q < n_q && n_q != '0))
    else $error("dispatch index out of range");

  // An accepted tick goes straight to the fill read-back
  a_tick_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == tws_pkg::CMD_TICK)
      |=> state_q == ST_TICK)
    else $error("tick not followed by fill read-back");

  // No result is loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result overwritten");
`endif

endmodule

### verif/timing_wheel_scheduler_top_tb.sv
module timing_wheel_scheduler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tws_pkg::*;

  // Run limits: the cycle ceiling allows for the clearing pass after reset, the long
  // receiver hold-off and every tick dispatching a full slot into a mostly stalled sink.
  localparam int unsigned LIMIT_CYCLES    = 200000;
  localparam int unsigned END_WAIT_CYCLES = 20;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned SEGMENTS        = 6;
  localparam int unsigned SEG_REQUESTS    = 15;
  localparam int unsigned TICK_PCT        = 30;

  localparam int unsigned WHEEL_SLOTS = SLOTS_DEF;
  localparam int unsigned SLOT_DEPTH  = SLOT_CAPACITY_DEF;

  // One expected result on the master side
  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] handle;
    logic                last;
  } due_result_t;

  // Directed stimulus table
  typedef enum logic {
    ROW_REQUEST = 1'b0,
    ROW_CONFIG  = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [WHEEL_SIZE_W-1:0] size;    // ROW_CONFIG only
    logic                    cmd;
    logic [DELAY_W-1:0]      delay;
    logic [HANDLE_W-1:0]     handle;  // incremented across repeats
    logic [4:0]              reps;
    logic                    pinned;  // expected status typed in below
    status_e                 status;
  } stim_row_t;

  localparam int unsigned DIRECTED_ROWS = 15;

  localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    // Reset state: size 64, position 0, all slots empty
    '{ROW_REQUEST, 7'd0,   CMD_TICK,     8'd0,   16'h0000, 5'd1,  1'b1, STAT_EMPTY},
    '{ROW_REQUEST, 7'd0,   CMD_SCHEDULE, 8'd255, 16'hFFFF, 5'd1,  1'b1, STAT_TOO_LATE},
    '{ROW_REQUEST, 7'd0,   CMD_SCHEDULE, 8'd64,  16'h0000, 5'd1,  1'b1, STAT_TOO_LATE},
    // Largest legal delay lands in slot 0, fired only after a wrap
    '{ROW_REQUEST, 7'd0,   CMD_SCHEDULE, 8'd63,  16'hFFFF, 5'd1,  1'b1, STAT_ACCEPTED},
    '{ROW_REQUEST, 7'd0,   CMD_SCHEDULE, 8'd1,   16'h0000, 5'd1,  1'b1, STAT_ACCEPTED},
    '{ROW_REQUEST, 7'd0,   CMD_SCHEDULE, 8'd1,   16'hA5A5, 5'd1,  1'b1, STAT_ACCEPTED},
    '{ROW_REQUEST, 7'd0,   CMD_TICK,     8'd0,   16'h0000, 5'd1,  1'b0, STAT_DISPATCH},
    // Size 0 behaves as 1; position now lies beyond the shrunk wheel
    '{ROW_CONFIG,  7'd0,   CMD_SCHEDULE, 8'd0,   16'h0000, 5'd0,  1'b0, STAT_ACCEPTED},
    '{ROW_REQUEST, 7'd0,   CMD_SCHEDULE, 8'd1,   16'h0000, 5'd1,  1'b1, STAT_TOO_LATE},
    '{ROW_REQUEST, 7'd0,   CMD_SCHEDULE, 8'd0,   16'h1111, 5'd1,  1'b1, STAT_ACCEPTED},
    '{ROW_REQUEST, 7'd0,   CMD_TICK,     8'd0,   16'h0000, 5'd1,  1'b0, STAT_DISPATCH},
    // Oversized register saturates at 64; fill one slot to capacity and past it
    '{ROW_CONFIG,  7'd127, CMD_SCHEDULE, 8'd0,   16'h0000, 5'd0,  1'b0, STAT_ACCEPTED},
    '{ROW_REQUEST, 7'd0,   CMD_SCHEDULE, 8'd1,   16'hC000, 5'd16, 1'b1, STAT_ACCEPTED},
    '{ROW_REQUEST, 7'd0,   CMD_SCHEDULE, 8'd1,   16'h7FFF, 5'd1,  1'b1, STAT_SLOT_FULL},
    '{ROW_REQUEST, 7'd0,   CMD_TICK,     8'd0,   16'h0000, 5'd1,  1'b0, STAT_DISPATCH}
  };

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [WHEEL_SIZE_W-1:0] cfg_data_i    = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [23:0]             s_axis_tdata  = '0;  // [7:0] delay_ticks, [23:8] handle_id
  logic [0:0]              s_axis_tuser  = '0;  // [0] command
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [23:0]             m_axis_tdata;        // [2:0] status, [18:3] due_handle, [23:19] zero
  logic                    m_axis_tlast;

  // Side-band travelling with each request, so the typed expectation is sampled at the
  // same edge as the request itself
  logic    req_pinned        = 1'b0;
  status_e req_pinned_status = STAT_ACCEPTED;

  // Idle rates in percent, and the receiver hold-off trigger
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_len      = 0;
  int unsigned hold_token    = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;

  int unsigned cycles     = 0;
  int unsigned mismatches = 0;

  // Shadow of the wheel
  logic [WHEEL_SIZE_W-1:0] wheel_size_q = WHEEL_SIZE_RESET;
  int unsigned             wheel_pos_q  = 0;
  logic [HANDLE_W-1:0]     slot_handles [WHEEL_SLOTS][SLOT_DEPTH];
  int unsigned             slot_count   [WHEEL_SLOTS];

  due_result_t due_results[$];
  due_result_t want;

  timing_wheel_scheduler_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Slots in use: 0 acts as 1, anything above the wheel saturates
  function automatic int unsigned wheel_span(logic [WHEEL_SIZE_W-1:0] size);
    if (size == 0) return 1;
    if (size > WHEEL_SLOTS) return WHEEL_SLOTS;
    return int'(size);
  endfunction

  // Append one expected result at the tail of the queue
  function automatic void queue_result(status_e status, logic [HANDLE_W-1:0] handle,
                                       logic last);
    due_result_t r;
    r.status = status;
    r.handle = handle;
    r.last   = last;
    due_results.insert(due_results.size(), r);
  endfunction

  // Update the shadow wheel for one request and queue the results it causes
  task automatic predict_wheel_results(logic cmd, logic [DELAY_W-1:0] delay,
                                       logic [HANDLE_W-1:0] handle);
    int unsigned span;
    int unsigned slot;
    int unsigned i;
    span = wheel_span(wheel_size_q);
    if (cmd == CMD_SCHEDULE) begin
      if (delay >= span) begin
        queue_result(STAT_TOO_LATE, 16'h0000, 1'b1);
      end else begin
        slot = (wheel_pos_q + delay) % span;
        if (slot_count[slot] >= SLOT_DEPTH) begin
          queue_result(STAT_SLOT_FULL, 16'h0000, 1'b1);
        end else begin
          slot_handles[slot][slot_count[slot]] = handle;
          slot_count[slot]++;
          queue_result(STAT_ACCEPTED, 16'h0000, 1'b1);
        end
      end
    end else begin
      // Wrap also catches a position stranded beyond a shrunk wheel
      if (wheel_pos_q >= span - 1) wheel_pos_q = 0;
      else wheel_pos_q++;
      slot = wheel_pos_q;
      if (slot_count[slot] == 0) begin
        queue_result(STAT_EMPTY, 16'h0000, 1'b1);
      end else begin
        for (i = 0; i < slot_count[slot]; i++)
          queue_result(STAT_DISPATCH, slot_handles[slot][i], (i + 1 == slot_count[slot]));
        slot_count[slot] = 0;
      end
    end
  endtask

  // Observe both sides at the clock edge: predict on accepted requests, check results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) wheel_size_q = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_wheel_results(s_axis_tuser[0], s_axis_tdata[7:0], s_axis_tdata[23:8]);
        // A typed row always gives one result; the table value stands in for the prediction
        if (req_pinned)
          due_results[due_results.size()-1] = '{req_pinned_status, 16'h0000, 1'b1};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, status %0d handle %h last %0b", $time,
                   m_axis_tdata[2:0], m_axis_tdata[18:3], m_axis_tlast);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (m_axis_tdata[2:0] !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     m_axis_tdata[2:0]);
            mismatches++;
          end
          if (m_axis_tdata[18:3] !== want.handle) begin
            $display("%0t: due_handle expected %h actual %h", $time, want.handle,
                     m_axis_tdata[18:3]);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, m_axis_tlast);
            mismatches++;
          end
          if (m_axis_tdata[23:19] !== 5'd0) begin
            $display("%0t: padding expected 0 actual %h", $time, m_axis_tdata[23:19]);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver: random back-pressure, or a long hold-off when the main flow asks for one
  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one request, with random idle cycles ahead of it; returns at the accepting edge
  task automatic push_request(logic cmd, logic [DELAY_W-1:0] delay,
                              logic [HANDLE_W-1:0] handle, logic pinned, status_e status);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid     <= 1'b1;
    s_axis_tdata      <= {handle, delay};
    s_axis_tuser      <= cmd;
    req_pinned        <= pinned;
    req_pinned_status <= status;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sender pauses until every expected result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
  endtask

  task automatic write_wheel_size(logic [WHEEL_SIZE_W-1:0] size);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned             r;
    int unsigned             k;
    int unsigned             seg;
    int unsigned             n;
    int unsigned             span;
    logic [DELAY_W-1:0]      delay;
    logic [WHEEL_SIZE_W-1:0] seg_size [SEGMENTS];

    for (r = 0; r < WHEEL_SLOTS; r++) slot_count[r] = 0;

    // Single reset at the start; the block then clears its fill memory and holds off
    // requests, which the handshake absorbs
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, sender and receiver both idling
    send_idle_pct = 14;
    recv_idle_pct = 81;
    for (r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CONFIG) begin
        drain_results();
        write_wheel_size(DIRECTED[r].size);
      end else begin
        for (k = 0; k < DIRECTED[r].reps; k++)
          push_request(DIRECTED[r].cmd, DIRECTED[r].delay, 16'(DIRECTED[r].handle + k),
                       DIRECTED[r].pinned, DIRECTED[r].status);
      end
    end

    // Random part: a new wheel size per segment, extremes included
    seg_size[0] = 7'd1;
    seg_size[1] = 7'd64;
    seg_size[2] = 7'($urandom_range(12, 3));
    seg_size[3] = 7'd127;
    seg_size[4] = 7'($urandom_range(127, 0));
    seg_size[5] = 7'd2;

    for (seg = 0; seg < SEGMENTS; seg++) begin
      // Idle pattern: sender light / receiver heavy, then swapped, then none at all
      case (seg / 2)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      drain_results();
      write_wheel_size(seg_size[seg]);
      span = wheel_span(seg_size[seg]);

      // Hold the sink off while requests keep coming, so the block backs up to its input
      if (seg == 4) begin
        hold_len = HOLD_OFF_CYCLES;
        hold_token++;
      end

      for (n = 0; n < SEG_REQUESTS; n++) begin
        if ($urandom_range(99) < TICK_PCT) begin
          // Unused fields still toggle on ticks
          push_request(CMD_TICK, 8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)),
                       1'b0, STAT_ACCEPTED);
        end else begin
          // Mostly in range, some late ones over the whole field
          if ($urandom_range(9) < 8) delay = 8'($urandom_range(span - 1, 0));
          else delay = 8'($urandom_range(255));
          push_request(CMD_SCHEDULE, delay, 16'($urandom_range(16'hFFFF)), 1'b0,
                       STAT_ACCEPTED);
        end
      end
    end

    drain_results();
    repeat (END_WAIT_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/tws_pkg.sv
hdl/tws_ram.sv
hdl/timing_wheel_scheduler_top.sv
verif/timing_wheel_scheduler_top_tb.sv
